// ===== sv/psf_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and helpers for the PNG scanline filter.
package psf_pkg;

   // Defaults for the top-level parameters
   localparam int unsigned MaxLineBytesDef = 16384;
   localparam int unsigned MaxBppDef       = 8;

   // Neighbor history depth (covers the largest pixel size)
   localparam int unsigned HistDepth = 8;
   localparam int unsigned HistIdxW  = $clog2(HistDepth);

   localparam int unsigned MinLineBytes = 2;

   // APB register file geometry
   localparam int unsigned CsrAddrW = 4;
   localparam int unsigned CsrDataW = 32;

   typedef enum logic [1:0] {
      REG_DECODE_MODE = 2'd0,
      REG_BYTES_PER_PIXEL = 2'd1,
      REG_LINE_BYTES = 2'd2
   } reg_idx_type;

   // Filter-type codes carried in the first byte of a scanline
   localparam logic [7:0] FILT_NONE    = 8'd0;
   localparam logic [7:0] FILT_SUB     = 8'd1;
   localparam logic [7:0] FILT_UP      = 8'd2;
   localparam logic [7:0] FILT_AVERAGE = 8'd3;
   localparam logic [7:0] FILT_PAETH   = 8'd4;

   typedef struct packed {
      logic        decode_mode;
      logic [3:0]  bytes_per_pixel;
      logic [14:0] line_bytes;
   } cfg_type;

   localparam cfg_type CfgReset = '{decode_mode: 1'b1, bytes_per_pixel: 4'd1,
                                    line_bytes: 15'd2};

   function automatic logic [9:0] abs10(input logic signed [9:0] v);
      abs10 = v[9] ? 10'(-v) : 10'(v);
   endfunction

endpackage

// ===== sv/psf_csr.sv =====
`timescale 1ns / 1ps
// APB-style configuration registers of the PNG scanline filter.
module psf_csr (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [psf_pkg::CsrAddrW-1:0] paddr,
   input  logic [psf_pkg::CsrDataW-1:0] pwdata,
   output logic [psf_pkg::CsrDataW-1:0] prdata,
   output logic                         pready,
   output psf_pkg::cfg_type             cfg
);

   psf_pkg::cfg_type cfg_ff, cfg_in;
   logic [1:0]       reg_idx;
   logic             wr_en;

   assign pready  = 1'b1;
   assign reg_idx = paddr[psf_pkg::CsrAddrW-1:2];
   assign wr_en   = psel & penable & pwrite;
   assign cfg     = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_idx)
            psf_pkg::REG_DECODE_MODE:     cfg_in.decode_mode     = pwdata[0];
            psf_pkg::REG_BYTES_PER_PIXEL: cfg_in.bytes_per_pixel = pwdata[3:0];
            psf_pkg::REG_LINE_BYTES:      cfg_in.line_bytes      = pwdata[14:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         psf_pkg::REG_DECODE_MODE:     prdata = psf_pkg::CsrDataW'(cfg_ff.decode_mode);
         psf_pkg::REG_BYTES_PER_PIXEL: prdata = psf_pkg::CsrDataW'(cfg_ff.bytes_per_pixel);
         psf_pkg::REG_LINE_BYTES:      prdata = psf_pkg::CsrDataW'(cfg_ff.line_bytes);
         default:                      prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= psf_pkg::CfgReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== sv/psf_line_mem.sv =====
`timescale 1ns / 1ps
// Previous-row line store: one write port, one registered read port.
module psf_line_mem #(
   parameter int unsigned DEPTH = psf_pkg::MaxLineBytesDef,
   parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [7:0]        rd_data,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [7:0]        wr_data
);

   logic [7:0] mem_ff [DEPTH];
   logic [7:0] rd_data_ff;

   assign rd_data = rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

endmodule

// ===== sv/psf_predictor.sv =====
`timescale 1ns / 1ps
// Predictor select: None, Sub, Up, Average and Paeth.
module psf_predictor (
   input  logic [7:0] filter_type,
   input  logic [7:0] left,
   input  logic [7:0] up,
   input  logic [7:0] up_left,
   output logic [7:0] pred
);

   logic [8:0] avg_sum;
   logic [9:0] pa, pb, pc;
   logic [7:0] paeth;

   assign avg_sum = {1'b0, left} + {1'b0, up};

   // pa = |b-c|, pb = |a-c|, pc = |a+b-2c|
   assign pa = psf_pkg::abs10(signed'({2'b00, up}) - signed'({2'b00, up_left}));
   assign pb = psf_pkg::abs10(signed'({2'b00, left}) - signed'({2'b00, up_left}));
   assign pc = psf_pkg::abs10(signed'({1'b0, avg_sum}) - signed'({1'b0, up_left, 1'b0}));

   always_comb begin
      if (pa <= pb && pa <= pc) begin
         paeth = left;
      end else if (pb <= pc) begin
         paeth = up;
      end else begin
         paeth = up_left;
      end
   end

   always_comb begin
      unique case (filter_type)
         psf_pkg::FILT_SUB:     pred = left;
         psf_pkg::FILT_UP:      pred = up;
         psf_pkg::FILT_AVERAGE: pred = avg_sum[8:1];
         psf_pkg::FILT_PAETH:   pred = paeth;
         default:               pred = 8'd0;  // None and unknown types
      endcase
   end

endmodule

// ===== sv/png_scanline_filter.sv =====
`timescale 1ns / 1ps
// PNG scanline filter / unfilter: top level with pipeline control and neighbor history.
//
// Input channel (req_*): one byte of the image stream per item; req_start_of_image
// marks the first byte of an image and restarts row and column. The first byte of
// each scanline is the filter-type byte and comes out unchanged with
// rsp_is_filter_byte set; later bytes are filtered (decode_mode 0: byte minus
// predictor) or reconstructed (decode_mode 1: byte plus predictor), mod 256.
// Result channel (rsp_*): exactly one item per input item, in order.
// Config: APB-style, decode_mode at 0x0, bytes_per_pixel at 0x4, line_bytes at 0x8;
// write only while no item is in flight.
// An accepted item is registered in stage 1 and then in the output register, from
// which it is on rsp_*. Throughput: one item per clock unless a held result stalls.
// The line store is read at accept and written one stage later; neighbor
// history is read and written in that same stage.
// Stall: a held result keeps rsp_* steady; stage 1 then holds and req_ready drops
// in the same cycle, so nothing is lost. Reset clears the pipeline, position and
// history and loads register defaults; the line store needs no clearing, since the
// first row of an image ignores what it reads.
module png_scanline_filter #(
   parameter int unsigned MAX_LINE_BYTES      = psf_pkg::MaxLineBytesDef,
   parameter int unsigned MAX_BYTES_PER_PIXEL = psf_pkg::MaxBppDef
) (
   input  logic                         clock,
   input  logic                         reset,
   // input items
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [7:0]                   req_data_in,
   input  logic                         req_start_of_image,
   // result items
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [7:0]                   rsp_data_out,
   output logic                         rsp_is_filter_byte,
   // configuration
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [psf_pkg::CsrAddrW-1:0] paddr,
   input  logic [psf_pkg::CsrDataW-1:0] pwdata,
   output logic [psf_pkg::CsrDataW-1:0] prdata,
   output logic                         pready
);

   localparam int unsigned AddrW = $clog2(MAX_LINE_BYTES);
   localparam int unsigned LenW  = $clog2(MAX_LINE_BYTES + 1);
   localparam int unsigned CmpW  = (LenW > 15) ? LenW : 15;
   localparam int unsigned HIdxW = psf_pkg::HistIdxW;

   psf_pkg::cfg_type cfg;

   // ---------------- configuration, clamped ----------------
   logic [CmpW-1:0] len_eff, line_bytes_x;
   logic [3:0]      bpp_eff;

   psf_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   assign line_bytes_x = CmpW'(cfg.line_bytes);

   always_comb begin
      if (line_bytes_x < CmpW'(psf_pkg::MinLineBytes)) begin
         len_eff = CmpW'(psf_pkg::MinLineBytes);
      end else if (line_bytes_x > CmpW'(MAX_LINE_BYTES)) begin
         len_eff = CmpW'(MAX_LINE_BYTES);
      end else begin
         len_eff = line_bytes_x;
      end
   end

   always_comb begin
      if (cfg.bytes_per_pixel == 4'd0) begin
         bpp_eff = 4'd1;
      end else if (cfg.bytes_per_pixel > 4'(MAX_BYTES_PER_PIXEL)) begin
         bpp_eff = 4'(MAX_BYTES_PER_PIXEL);
      end else begin
         bpp_eff = cfg.bytes_per_pixel;
      end
   end

   // ---------------- stage 0: accept, line position ----------------
   logic             req_acc;
   logic [AddrW-1:0] column_ff, column_in, col_cur;
   logic             first_row_ff, first_row_in, first_cur;
   logic [7:0]       row_filter_ff, row_filter_in;
   logic             is_filt;
   logic [CmpW-1:0]  col_next;

   assign req_acc  = req_valid & req_ready;
   assign col_cur  = req_start_of_image ? '0 : column_ff;
   assign first_cur = req_start_of_image | first_row_ff;
   assign is_filt  = (col_cur == '0);
   assign col_next = CmpW'(col_cur) + CmpW'(1);

   always_comb begin
      column_in     = column_ff;
      first_row_in  = first_row_ff;
      row_filter_in = row_filter_ff;
      if (req_acc) begin
         if (is_filt) begin
            row_filter_in = req_data_in;
            column_in     = AddrW'(1);
            first_row_in  = first_cur;
         end else if (col_next >= len_eff) begin
            // last byte of the line (also when line_bytes was lowered)
            column_in    = '0;
            first_row_in = 1'b0;
         end else begin
            column_in    = col_next[AddrW-1:0];
            first_row_in = first_cur;
         end
      end
   end

   // ---------------- stage 1: predict and update ----------------
   logic             s1_valid_ff, s1_valid_in, s1_adv;
   logic [7:0]       s1_data_ff;
   logic             s1_filter_ff;
   logic [AddrW-1:0] s1_pos_ff;
   logic             s1_first_ff;
   logic [7:0]       s1_kind_ff;

   logic [7:0]       mem_rd_data;
   logic             mem_rd_en;
   logic             mem_wr_en;

   logic [7:0]       left_hist_ff  [psf_pkg::HistDepth];
   logic [7:0]       upper_hist_ff [psf_pkg::HistDepth];

   logic [CmpW-1:0]  pos_x;
   logic             has_left;
   logic [HIdxW-1:0] nb_idx, wr_idx;
   logic [7:0]       nb_a, nb_b, nb_c, pred, result, stored;

   assign pos_x    = CmpW'(s1_pos_ff);
   assign has_left = pos_x > CmpW'(bpp_eff);
   assign nb_idx   = pos_x[HIdxW-1:0] - bpp_eff[HIdxW-1:0];
   assign wr_idx   = pos_x[HIdxW-1:0];

   assign nb_b = s1_first_ff ? 8'd0 : mem_rd_data;
   assign nb_a = has_left ? left_hist_ff[nb_idx] : 8'd0;
   assign nb_c = (has_left && !s1_first_ff) ? upper_hist_ff[nb_idx] : 8'd0;

   psf_predictor u_pred (
      .filter_type (s1_kind_ff),
      .left        (nb_a),
      .up          (nb_b),
      .up_left     (nb_c),
      .pred        (pred)
   );

   assign result = cfg.decode_mode ? (s1_data_ff + pred) : (s1_data_ff - pred);
   assign stored = cfg.decode_mode ? result : s1_data_ff;

   // output register
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_data_ff;
   logic       rsp_filt_ff;

   assign s1_adv      = s1_valid_ff & (~rsp_valid_ff | rsp_ready);
   assign req_ready   = ~s1_valid_ff | s1_adv;
   assign s1_valid_in = req_acc | (s1_valid_ff & ~s1_adv);
   assign rsp_valid_in = s1_adv | (rsp_valid_ff & ~rsp_ready);

   // Reads happen at accept, writes as stage 1 retires. Same-column accesses are
   // always at least a full line apart, so no forwarding is needed.
   assign mem_rd_en = req_acc & ~is_filt;
   assign mem_wr_en = s1_adv & ~s1_filter_ff;

   psf_line_mem #(
      .DEPTH  (MAX_LINE_BYTES),
      .ADDR_W (AddrW)
   ) u_line_mem (
      .clock   (clock),
      .rd_en   (mem_rd_en),
      .rd_addr (col_cur),
      .rd_data (mem_rd_data),
      .wr_en   (mem_wr_en),
      .wr_addr (s1_pos_ff),
      .wr_data (stored)
   );

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_data_out       = rsp_data_ff;
   assign rsp_is_filter_byte = rsp_filt_ff;

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff     <= '0;
         first_row_ff  <= 1'b1;
         row_filter_ff <= psf_pkg::FILT_NONE;
         s1_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         column_ff     <= column_in;
         first_row_ff  <= first_row_in;
         row_filter_ff <= row_filter_in;
         s1_valid_ff   <= s1_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // neighbor history, zero at reset
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < int'(psf_pkg::HistDepth); i++) begin
            left_hist_ff[i]  <= 8'd0;
            upper_hist_ff[i] <= 8'd0;
         end
      end else if (mem_wr_en) begin
         left_hist_ff[wr_idx]  <= stored;
         upper_hist_ff[wr_idx] <= nb_b;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (req_acc) begin
         s1_data_ff   <= req_data_in;
         s1_filter_ff <= is_filt;
         s1_pos_ff    <= col_cur;
         s1_first_ff  <= first_cur;
         s1_kind_ff   <= row_filter_ff;
      end
      if (s1_adv) begin
         rsp_data_ff <= s1_filter_ff ? s1_data_ff : result;
         rsp_filt_ff <= s1_filter_ff;
      end
   end

`ifndef SYNTHESIS
   // line store never sees a read and a write of the same column in one cycle
   a_mem_no_collision: assert property (@(posedge clock) disable iff (reset)
      (mem_rd_en && mem_wr_en) |-> (col_cur != s1_pos_ff))
      else $error("line store read and write hit the same column");

   // a start-of-image item always lands in stage 1 as a filter-type byte
   a_soi_is_filter: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_start_of_image) |=> (s1_valid_ff && s1_filter_ff))
      else $error("start of image not taken as filter-type byte");

   // out of reset the block is on the first row with an empty pipeline
   a_reset_state: assert property (@(posedge clock)
      $fell(reset) |-> (first_row_ff && !s1_valid_ff && !rsp_valid_ff))
      else $error("bad state after reset");
`endif

endmodule
